// ----- rtl/rlbs_pkg.sv -----
package rlbs_pkg;

  // alphabet and histogram geometry
  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned HIST_DEPTH    = 256;
  localparam int unsigned HIST_AW       = 8;
  localparam int unsigned QCNT_W        = 9;

  localparam logic [31:0] LEN_LIMIT = 32'hFFFF_FFFF;

  // input word layout (s_tdata)
  localparam int unsigned IN_W      = 80;
  localparam int unsigned IN_SYM_LO = 0;
  localparam int unsigned IN_SA_LO  = 8;
  localparam int unsigned IN_QRY_LO = 72;

  // output word layout (m_tdata)
  localparam int unsigned OUT_W      = 304;
  localparam int unsigned OUT_SYM_LO = 0;
  localparam int unsigned OUT_LEN_LO = 8;
  localparam int unsigned OUT_SA_LO  = 40;
  localparam int unsigned OUT_RUN_LO = 104;
  localparam int unsigned OUT_ELM_LO = 168;
  localparam int unsigned OUT_WID_LO = 232;
  localparam int unsigned OUT_PFX_LO = 239;
  localparam int unsigned OUT_OVF    = 303;

  // input kinds
  localparam logic KIND_ELEM  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result kinds
  localparam logic [1:0] RK_RUN    = 2'd0;
  localparam logic [1:0] RK_SUM    = 2'd1;
  localparam logic [1:0] RK_PREFIX = 2'd2;

  // register map
  localparam int unsigned APB_AW       = 4;
  localparam logic        REG_TEXT_LEN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_EOS_RUN,
    ST_EOS_SUM,
    ST_QRUN
  } state_t;

  typedef struct packed {
    logic take;       // word accepted on the input
    logic upd;        // apply element to run and histogram
    logic emit_final; // emit the closing run
    logic emit_sum;   // emit stream summary
    logic q_step;     // prefix walk step
    logic emit_q;     // emit prefix answer
  } cmd_t;

  typedef struct packed {
    logic need_emit;  // element closes the open run
    logic eos;
    logic q_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/bwt_run_length_sampler_unit.sv -----
// Run-length BWT sampler.
// Slave stream: one word per BWT position (tuser = 0) or a prefix-count
//   read (tuser = 1). tlast marks the final element of a stream.
// Master stream: run records, a stream summary after the last run, and
//   prefix-count answers; tuser gives the result kind, tlast the last
//   result caused by one input word.
// APB: one 64-bit register, the text length used for the sample width
//   (0 selects the counted stream length). Write it only while idle.
// Timing: an element is accepted in IDLE; in UPD its histogram entry is
//   read-modify-written through the separate RAM read and write ports, and
//   a run record it closes is registered, UPD waiting while the output
//   register is occupied. A final element then emits the closing run and
//   the summary in turn. A prefix read walks the histogram one entry a cycle.
// Reset clears the run state, counters and histogram valid bits; the
//   histogram RAM itself needs no clearing pass. The first element after
//   a summary starts a new stream with cleared counts.
// A stalled master side holds the result in the output register; the
//   block still accepts a word and stops only when its next result needs
//   the occupied register.
module bwt_run_length_sampler_unit (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rlbs_pkg::IN_W-1:0]         s_tdata,  // bwt_symbol, sa_value, query_symbol
  input  logic                              s_tuser,  // kind
  input  logic                              s_tlast,  // end_of_stream
  // master stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rlbs_pkg::OUT_W-1:0]        m_tdata,  // run_symbol, run_length, run_end_sa,
                                                      // run_total, stream_length, sample_width,
                                                      // prefix_count, length_overflow
  output logic [1:0]                        m_tuser,  // result_kind
  output logic                              m_tlast,  // last_result
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlbs_pkg::APB_AW-1:0]       paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  rlbs_pkg::cmd_t cmd;
  rlbs_pkg::sts_t sts;

  logic [63:0] text_len;
  logic        reg_sel;

  // registers sit on 8-byte boundaries
  assign reg_sel = paddr[rlbs_pkg::APB_AW-1] == rlbs_pkg::REG_TEXT_LEN;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? text_len : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_len <= 64'd0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_len <= pwdata;
    end
  end

  rlbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlbs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .text_len (text_len),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/rlbs_ram.sv -----
module rlbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rlbs_ctrl.sv -----
module rlbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  input  rlbs_pkg::sts_t   sts,
  output rlbs_pkg::cmd_t   cmd
);

  rlbs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rlbs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == rlbs_pkg::KIND_QUERY) ? rlbs_pkg::ST_QRUN
                                                         : rlbs_pkg::ST_UPD;
        end
      end
      rlbs_pkg::ST_UPD: begin
        if (!sts.need_emit || sts.out_free) begin
          state_next = sts.eos ? rlbs_pkg::ST_EOS_RUN : rlbs_pkg::ST_IDLE;
        end
      end
      rlbs_pkg::ST_EOS_RUN: begin
        if (sts.out_free) state_next = rlbs_pkg::ST_EOS_SUM;
      end
      rlbs_pkg::ST_EOS_SUM: begin
        if (sts.out_free) state_next = rlbs_pkg::ST_IDLE;
      end
      rlbs_pkg::ST_QRUN: begin
        if (sts.q_done && sts.out_free) state_next = rlbs_pkg::ST_IDLE;
      end
      default: state_next = rlbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      rlbs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      rlbs_pkg::ST_UPD:     cmd.upd        = !sts.need_emit || sts.out_free;
      rlbs_pkg::ST_EOS_RUN: cmd.emit_final = sts.out_free;
      rlbs_pkg::ST_EOS_SUM: cmd.emit_sum   = sts.out_free;
      rlbs_pkg::ST_QRUN: begin
        cmd.q_step = 1'b1;
        cmd.emit_q = sts.q_done && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/rlbs_dp.sv -----
module rlbs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rlbs_pkg::IN_W-1:0]     s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  input  logic [63:0]                   text_len,
  input  rlbs_pkg::cmd_t                cmd,
  output rlbs_pkg::sts_t                sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rlbs_pkg::OUT_W-1:0]    m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast
);

  // captured input word
  logic [7:0]                   sym_q;
  logic [63:0]                  sa_q;
  logic                         eos_q;
  logic [rlbs_pkg::QCNT_W-1:0]  qlim_q;

  // run and stream state
  logic        run_open;
  logic [7:0]  cur_sym;
  logic [32:0] cur_len;
  logic [63:0] prev_sa;
  logic [63:0] runs, runs_next;
  logic [63:0] elems;
  logic        ovf;
  logic        done;
  logic        restart;

  // histogram
  logic [rlbs_pkg::HIST_DEPTH-1:0] hvalid;
  logic [rlbs_pkg::HIST_AW-1:0]    raddr, raddr_q;
  logic [63:0]                     rdata, hist_rd;

  // prefix walk
  logic [rlbs_pkg::QCNT_W-1:0] qi;
  logic                        pend;
  logic [63:0]                 sum;
  logic                        q_more;

  // width search, byte stage
  logic [63:0]      lim;
  logic [7:0]       nz_q;
  logic [7:0][2:0]  pos_c;
  logic [7:0][2:0]  pos_q;
  logic [6:0]       width;

  logic [7:0]  in_sym, sym_c;
  logic [7:0]  in_qry;
  logic [32:0] len_inc;
  logic [31:0] len_sat;
  logic        emit_upd;

  logic                       load;
  logic [rlbs_pkg::OUT_W-1:0] out_data;
  logic [1:0]                 out_kind;
  logic                       out_last;

  assign in_sym = s_tdata[rlbs_pkg::IN_SYM_LO +: 8];
  assign in_qry = s_tdata[rlbs_pkg::IN_QRY_LO +: 8];
  assign sym_c  = ({1'b0, in_sym} >= 9'(rlbs_pkg::ALPHABET_SIZE))
                  ? 8'(rlbs_pkg::ALPHABET_SIZE - 1) : in_sym;

  assign hist_rd = hvalid[raddr_q] ? rdata : 64'd0;
  assign q_more  = qi < qlim_q;

  assign sts.need_emit = run_open && (sym_q != cur_sym);
  assign sts.eos       = eos_q;
  assign sts.q_done    = !q_more && !pend;
  assign sts.out_free  = !m_tvalid || m_tready;

  // first element after a summary opens a new stream
  assign restart  = cmd.take && s_tuser == rlbs_pkg::KIND_ELEM && done;
  assign emit_upd = cmd.upd && sts.need_emit;
  assign len_inc  = (cur_len <= {1'b0, rlbs_pkg::LEN_LIMIT}) ? cur_len + 33'd1 : cur_len;
  assign len_sat  = cur_len[32] ? rlbs_pkg::LEN_LIMIT : cur_len[31:0];

  always_comb begin
    raddr = sym_q;
    if (cmd.take) begin
      raddr = sym_c;
    end else if (cmd.q_step && q_more) begin
      raddr = qi[rlbs_pkg::HIST_AW-1:0];
    end
  end

  rlbs_ram #(.WIDTH(64), .DEPTH(rlbs_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (sym_q),
    .wdata (hist_rd + 64'd1),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    runs_next = runs;
    if (restart) begin
      runs_next = 64'd0;
    end else if (emit_upd || cmd.emit_final) begin
      runs_next = runs + 64'd1;
    end
  end

  // sample width: byte-wise leading-one stage, then pick the top byte
  assign lim = ((text_len != 64'd0) ? text_len : elems) - 64'd1;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pos_c[b] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (lim[b*8 + i]) pos_c[b] = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      nz_q[b] <= |lim[b*8 +: 8];
    end
    pos_q <= pos_c;
  end

  always_comb begin
    width = 7'd1;
    for (int b = 0; b < 8; b++) begin
      if (nz_q[b]) width = 7'({3'(b), pos_q[b]}) + 7'd1;
    end
  end

  // captured word and walk registers
  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (cmd.take) begin
      sym_q  <= sym_c;
      sa_q   <= s_tdata[rlbs_pkg::IN_SA_LO +: 64];
      eos_q  <= s_tlast;
      qlim_q <= ({1'b0, in_qry} > 9'(rlbs_pkg::ALPHABET_SIZE))
                ? 9'(rlbs_pkg::ALPHABET_SIZE) : {1'b0, in_qry};
      qi     <= '0;
      sum    <= 64'd0;
    end else if (cmd.q_step) begin
      if (q_more) qi <= qi + 9'd1;
      if (pend) sum <= sum + hist_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.take) begin
      pend <= 1'b0;
    end else if (cmd.q_step) begin
      pend <= q_more;
    end
  end

  // run and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
      cur_sym  <= 8'd0;
      cur_len  <= 33'd0;
      prev_sa  <= 64'd0;
      runs     <= 64'd0;
      elems    <= 64'd0;
      ovf      <= 1'b0;
      done     <= 1'b0;
      hvalid   <= '0;
    end else begin
      runs <= runs_next;
      if (restart) begin
        hvalid <= '0;
        elems  <= 64'd0;
        ovf    <= 1'b0;
        done   <= 1'b0;
      end
      if (cmd.upd) begin
        if (!run_open || sts.need_emit) begin
          run_open <= 1'b1;
          cur_sym  <= sym_q;
          cur_len  <= 33'd1;
        end else begin
          cur_len <= len_inc;
          if (len_inc[32]) ovf <= 1'b1;
        end
        prev_sa        <= sa_q;
        elems          <= elems + 64'd1;
        hvalid[sym_q]  <= 1'b1;
      end
      if (cmd.emit_sum) begin
        run_open <= 1'b0;
        cur_sym  <= 8'd0;
        cur_len  <= 33'd0;
        done     <= 1'b1;
      end
    end
  end

  // output word
  always_comb begin
    load     = emit_upd || cmd.emit_final || cmd.emit_sum || cmd.emit_q;
    out_data = '0;
    out_kind = rlbs_pkg::RK_RUN;
    out_last = 1'b0;
    out_data[rlbs_pkg::OUT_OVF] = ovf;
    priority if (cmd.emit_sum) begin
      out_kind = rlbs_pkg::RK_SUM;
      out_last = 1'b1;
      out_data[rlbs_pkg::OUT_RUN_LO +: 64] = runs;
      out_data[rlbs_pkg::OUT_ELM_LO +: 64] = elems;
      out_data[rlbs_pkg::OUT_WID_LO +: 7]  = width;
    end else if (cmd.emit_q) begin
      out_kind = rlbs_pkg::RK_PREFIX;
      out_last = 1'b1;
      out_data[rlbs_pkg::OUT_PFX_LO +: 64] = sum;
    end else begin
      out_last = emit_upd && !eos_q;
      out_data[rlbs_pkg::OUT_SYM_LO +: 8]  = cur_sym;
      out_data[rlbs_pkg::OUT_LEN_LO +: 32] = len_sat;
      out_data[rlbs_pkg::OUT_SA_LO +: 64]  = prev_sa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= out_data;
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

endmodule

// ----- rtl/rlbs_chk.sv -----
module rlbs_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rlbs_pkg::OUT_W-1:0]     m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);

  logic [31:0] len;
  logic [6:0]  wid;

  assign len = m_tdata[rlbs_pkg::OUT_LEN_LO +: 32];
  assign wid = m_tdata[rlbs_pkg::OUT_WID_LO +: 7];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rlbs_pkg::RK_RUN |-> len != 32'd0)
    else $error("run record with zero length");

  a_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rlbs_pkg::RK_SUM || m_tuser == rlbs_pkg::RK_PREFIX) |-> m_tlast)
    else $error("summary or prefix answer not marked last");

  a_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rlbs_pkg::RK_SUM |-> wid != 7'd0 && wid <= 7'd64)
    else $error("sample width out of range");

endmodule

bind bwt_run_length_sampler_unit rlbs_chk u_rlbs_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
